[rtl/assert_macros.svh]
// Concurrent check helpers; they expect clk and arst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/fum_pkg.sv]
package fum_pkg;

	localparam int unsigned FRAME_BITS = 11;
	localparam longint unsigned Q30_ONE = 64'd1073741824;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	// divisors (2k)(2k+1) of the sine series terms, k = 1..8
	localparam longint unsigned TERM_DIV [1:8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	typedef logic [FRAME_BITS-1:0] frame_t;
	typedef logic [3:0] bit_cnt_t;

	typedef enum logic {
		REQ_BYTE = 1'b0,
		REQ_TICK = 1'b1
	} req_kind_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] byte_value;
	} fum_in_t;

	typedef struct packed {
		logic [7:0] duty;
		logic       duty_valid;
		logic       byte_taken;
		logic       line_idle;
	} fum_out_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic last;
	} fum_qstat_t;

endpackage

[rtl/fum_req_if.sv]
interface fum_req_if import fum_pkg::*; ();
	logic    valid;
	logic    ready;
	fum_in_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[rtl/fum_rsp_if.sv]
interface fum_rsp_if import fum_pkg::*; ();
	logic     valid;
	logic     ready;
	fum_out_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[rtl/fum_frame_queue.sv]
`include "assert_macros.svh"

module fum_frame_queue import fum_pkg::*; #(
	parameter int unsigned DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  frame_t     push_data,
	input  logic       pop,
	output frame_t     head_data,
	output fum_qstat_t stat
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	frame_t          mem_q [DEPTH];
	frame_t          rd_data_q;
	logic [AW-1:0]   head_q;
	logic [AW-1:0]   tail_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   head_d;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head_d = pop ? ptr_inc(head_q) : head_q;

	// prefetch the entry at the next head; forward a write to that same slot
	always_ff @(posedge clk) begin
		if (push)
			mem_q[tail_q] <= push_data;
		if (push && (tail_q == head_d))
			rd_data_q <= push_data;
		else
			rd_data_q <= mem_q[head_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_d;
			if (push)
				tail_q <= ptr_inc(tail_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head_data  = rd_data_q;
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.last  = (count_q == CW'(1));

	`ASSERT_NEVER(a_push_full, push && stat.full, "push into a full frame queue")
	`ASSERT_NEVER(a_pop_empty, pop && stat.empty, "pop from an empty frame queue")
	`ASSERT_CHK(a_count_up, push && !pop |=> count_q == $past(count_q) + 1'b1, "count did not advance on push")

endmodule

[rtl/fsk_uart_pwm_modulator.sv]
// A result is captured in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is empty or taken; the tone ROM read and
// the bit/queue update settle combinationally between the state and output registers.
// Reset (arst_n low, asynchronous): queue empty, line idle on the mark tone,
// sample counter at zero, output register empty. Queue storage is not cleared.
`include "assert_macros.svh"

module fsk_uart_pwm_modulator import fum_pkg::*; #(
	parameter int unsigned FRAME_DEPTH     = 32,
	parameter int unsigned SAMPLES_PER_BIT = 82,
	parameter int unsigned PWM_MODULO      = 254
) (
	input logic      clk,
	input logic      arst_n,
	fum_req_if.sink  req,
	fum_rsp_if.source rsp
);

	localparam int unsigned TICKS_PER_BIT = 2 * SAMPLES_PER_BIT;
	localparam int unsigned SIDX_W        = $clog2(TICKS_PER_BIT);
	localparam int unsigned ROM_AW        = SIDX_W - 1;

	// Q30 sine of 2*pi*q/N, folded by quadrant, mapped to a PWM compare value
	function automatic logic [7:0] duty_at(input int unsigned q);
		longint unsigned quad;
		longint unsigned r;
		longint unsigned a;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned lift;
		longint unsigned v;
		longint          s;
		int              k;
		quad = (4 * longint'(q)) / SAMPLES_PER_BIT;
		r    = 4 * longint'(q) - quad * SAMPLES_PER_BIT;
		a    = quad[0] ? SAMPLES_PER_BIT - r : r;
		if (a == 0) begin
			s = 0;
		end else if (a == SAMPLES_PER_BIT) begin
			s = longint'(Q30_ONE);
		end else if (3 * a == SAMPLES_PER_BIT) begin
			s = longint'(Q30_ONE / 2);
		end else begin
			x    = HALF_PI_Q30 * a / SAMPLES_PER_BIT;
			x2   = (x * x) >> 30;
			term = x;
			s    = longint'(x);
			for (k = 1; k <= 8; k++) begin
				term = (term * x2) >> 30;
				term = term / TERM_DIV[k];
				if (k % 2 == 1)
					s = s - longint'(term);
				else
					s = s + longint'(term);
			end
			if (s < 0)
				s = 0;
			if (s > longint'(Q30_ONE))
				s = longint'(Q30_ONE);
		end
		if (quad >= 2)
			s = -s;
		lift = longint'(Q30_ONE) + s;
		v    = ((PWM_MODULO - 2) * lift + Q30_ONE) >> 31;
		return v[7:0] + 8'd1;
	endfunction

	logic [7:0] mark_tab  [SAMPLES_PER_BIT];
	logic [7:0] space_tab [SAMPLES_PER_BIT];

	for (genvar g = 0; g < SAMPLES_PER_BIT; g++) begin : g_rom
		assign mark_tab[g]  = duty_at(g);
		assign space_tab[g] = duty_at((2 * g) % SAMPLES_PER_BIT);
	end

	// state
	frame_t            shift_q;
	bit_cnt_t          bits_left_q;
	logic              tone_q;
	logic [SIDX_W-1:0] sidx_q;
	fum_out_t          rsp_q;
	logic              rsp_valid_q;

	// next state
	frame_t            shift_d;
	bit_cnt_t          bits_left_d;
	logic              tone_d;
	logic [SIDX_W-1:0] sidx_d;
	fum_out_t          rsp_d;

	logic              advance;
	logic              req_fire;
	logic              is_tick;
	logic              q_push;
	logic              q_pop;
	frame_t            q_head;
	frame_t            new_frame;
	fum_qstat_t        q_stat;
	logic [ROM_AW-1:0] rom_idx;
	logic              q_empty_after;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = advance;
	assign req_fire  = req.valid && advance;
	assign is_tick   = (req.payload.req_type == REQ_TICK);
	assign new_frame = {1'b1, ^req.payload.byte_value, req.payload.byte_value, 1'b0};
	assign q_push    = req_fire && !is_tick && !q_stat.full;
	assign rom_idx   = sidx_q[SIDX_W-1:1];

	fum_frame_queue #(
		.DEPTH(FRAME_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(new_frame),
		.pop      (q_pop),
		.head_data(q_head),
		.stat     (q_stat)
	);

	always_comb begin
		shift_d     = shift_q;
		bits_left_d = bits_left_q;
		tone_d      = tone_q;
		sidx_d      = sidx_q;
		q_pop       = 1'b0;
		if (req_fire && is_tick) begin
			// pick the next bit at the boundary
			if (sidx_q == '0) begin
				if (bits_left_q <= bit_cnt_t'(1)) begin
					if (!q_stat.empty) begin
						q_pop       = 1'b1;
						shift_d     = q_head;
						bits_left_d = bit_cnt_t'(FRAME_BITS);
					end else begin
						bits_left_d = '0;
					end
				end else begin
					bits_left_d = bits_left_q - 1'b1;
					shift_d     = shift_q >> 1;
				end
				tone_d = (bits_left_d != '0) ? shift_d[0] : 1'b1;
			end
			sidx_d = (sidx_q == SIDX_W'(TICKS_PER_BIT - 1)) ? '0 : sidx_q + 1'b1;
		end
	end

	always_comb begin
		if (q_push)
			q_empty_after = 1'b0;
		else if (q_pop)
			q_empty_after = q_stat.last;
		else
			q_empty_after = q_stat.empty;
		rsp_d.duty       = '0;
		rsp_d.duty_valid = 1'b0;
		rsp_d.byte_taken = q_push;
		rsp_d.line_idle  = q_empty_after && (bits_left_d == '0);
		if (is_tick) begin
			rsp_d.duty       = tone_d ? mark_tab[rom_idx] : space_tab[rom_idx];
			rsp_d.duty_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= '0;
			tone_q      <= 1'b1;
			sidx_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			bits_left_q <= bits_left_d;
			tone_q      <= tone_d;
			sidx_q      <= sidx_d;
			if (advance)
				rsp_valid_q <= req.valid;
		end
	end

	// payload registers: hold while the result beat is stalled
	always_ff @(posedge clk) begin
		shift_q <= shift_d;
		if (req_fire)
			rsp_q <= rsp_d;
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	`ASSERT_NEVER(a_sidx_range, sidx_q > SIDX_W'(TICKS_PER_BIT - 1), "sample index out of range")
	`ASSERT_CHK(a_idle_mark, bits_left_q == '0 |-> tone_q, "idle line not on the mark tone")
	`ASSERT_CHK(a_byte_no_duty, req_fire && !is_tick |=> rsp.valid && !rsp.payload.duty_valid, "byte beat produced a duty sample")

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
	import fum_pkg::*;

	localparam int unsigned FRAME_DEPTH     = 32;
	localparam int unsigned SAMPLES_PER_BIT = 82;
	localparam int unsigned PWM_MODULO      = 254;
	localparam int unsigned UART_BITS       = 11;
	localparam int unsigned CYCLE_LIMIT     = 300000;

	class duty_scoreboard;
		logic [7:0] mark_wave [SAMPLES_PER_BIT];
		logic [7:0] space_wave [SAMPLES_PER_BIT];
		frame_t     queued_frames [$];
		frame_t     shifter;
		int unsigned bits_to_go;
		logic       tone_mark;
		int unsigned sample_pos;
		fum_out_t   pending_outputs [$];
		int unsigned mismatches;

		function new();
			for (int unsigned i = 0; i < SAMPLES_PER_BIT; i++) begin
				mark_wave[i] = pwm_level(sine_fixed(i));
				space_wave[i] = pwm_level(sine_fixed((2 * i) % SAMPLES_PER_BIT));
			end
			bits_to_go = 0;
			tone_mark = 1'b1;
			sample_pos = 0;
			shifter = '0;
			mismatches = 0;
		endfunction

		// sine of 2*pi*step/SAMPLES_PER_BIT in Q30, folded to the first quadrant
		function longint sine_fixed(int unsigned step);
			longint one_q30, half_pi, x, x2, term, s;
			int unsigned quad, r, a, k;
			one_q30 = 64'sd1073741824;
			half_pi = 64'sd1686629713;
			quad = (4 * step) / SAMPLES_PER_BIT;
			r = 4 * step - quad * SAMPLES_PER_BIT;
			a = quad[0] ? SAMPLES_PER_BIT - r : r;
			if (a == 0) begin
				s = 0;
			end else if (a == SAMPLES_PER_BIT) begin
				s = one_q30;
			end else if (3 * a == SAMPLES_PER_BIT) begin
				s = one_q30 / 2;
			end else begin
				x = half_pi * longint'(a) / longint'(SAMPLES_PER_BIT);
				x2 = (x * x) >>> 30;
				term = x;
				s = x;
				for (k = 1; k <= 8; k++) begin
					term = (term * x2) >>> 30;
					term = term / longint'((2 * k) * (2 * k + 1));
					if (k[0])
						s = s - term;
					else
						s = s + term;
				end
				if (s < 0)
					s = 0;
				if (s > one_q30)
					s = one_q30;
			end
			return (quad >= 2) ? -s : s;
		endfunction

		// round half up of ((1+sin)/2)*(PWM_MODULO-2)+1
		function logic [7:0] pwm_level(longint s);
			longint lift, v;
			lift = 64'sd1073741824 + s;
			v = (longint'(PWM_MODULO - 2) * lift + 64'sd1073741824) >>> 31;
			return 8'(v + 1);
		endfunction

		function fum_out_t modulated_out(fum_in_t item);
			fum_out_t r;
			int unsigned idx;
			r = '0;
			if (item.req_type == REQ_BYTE) begin
				if (queued_frames.size() < FRAME_DEPTH) begin
					// stop, parity, data LSB first, start
					queued_frames.push_back({1'b1, ^item.byte_value, item.byte_value, 1'b0});
					r.byte_taken = 1'b1;
				end
			end else begin
				if (sample_pos == 0) begin
					if (bits_to_go <= 1) begin
						if (queued_frames.size() > 0) begin
							shifter = queued_frames.pop_front();
							bits_to_go = UART_BITS;
						end else begin
							bits_to_go = 0;
						end
					end else begin
						bits_to_go--;
						shifter = shifter >> 1;
					end
					tone_mark = (bits_to_go != 0) ? shifter[0] : 1'b1;
				end
				idx = sample_pos >> 1;
				r.duty = tone_mark ? mark_wave[idx] : space_wave[idx];
				r.duty_valid = 1'b1;
				sample_pos++;
				if (sample_pos >= 2 * SAMPLES_PER_BIT)
					sample_pos = 0;
			end
			r.line_idle = (queued_frames.size() == 0) && (bits_to_go == 0);
			return r;
		endfunction

		function void note_request(fum_in_t item);
			pending_outputs.push_back(modulated_out(item));
		endfunction

		function void check_response(fum_out_t got);
			fum_out_t want;
			if (pending_outputs.size() == 0) begin
				$error("unexpected response beat: %h", got);
				mismatches++;
				return;
			end
			want = pending_outputs.pop_front();
			if (got.duty !== want.duty) begin
				$error("duty: expected %0d, got %0d", want.duty, got.duty);
				mismatches++;
			end
			if (got.duty_valid !== want.duty_valid) begin
				$error("duty_valid: expected %0b, got %0b", want.duty_valid, got.duty_valid);
				mismatches++;
			end
			if (got.byte_taken !== want.byte_taken) begin
				$error("byte_taken: expected %0b, got %0b", want.byte_taken, got.byte_taken);
				mismatches++;
			end
			if (got.line_idle !== want.line_idle) begin
				$error("line_idle: expected %0b, got %0b", want.line_idle, got.line_idle);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	fum_req_if req_bus ();
	fum_rsp_if rsp_bus ();
	duty_scoreboard sb;

	int unsigned send_idle_pct;
	int unsigned stall_pct;
	bit hold_request;
	int unsigned hold_left;
	int unsigned cycle_count;

	fsk_uart_pwm_modulator #(
		.FRAME_DEPTH(FRAME_DEPTH),
		.SAMPLES_PER_BIT(SAMPLES_PER_BIT),
		.PWM_MODULO(PWM_MODULO)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic offer_item(input req_kind_t kind, input logic [7:0] value);
		fum_in_t item;
		item.req_type = kind;
		item.byte_value = value;
		while ($urandom_range(99) < send_idle_pct) begin
			req_bus.valid <= 1'b0;
			@(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.payload <= item;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		sb.note_request(item);
	endtask

	task automatic wait_drained();
		req_bus.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_outputs.size() != 0);
	endtask

	task automatic run_phase(input int unsigned count, input int unsigned byte_per_mille);
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(999) < byte_per_mille)
				offer_item(REQ_BYTE, 8'($urandom_range(255)));
			else
				offer_item(REQ_TICK, 8'($urandom_range(255)));
		end
	endtask

	// response side: random stalls, plus one long hold-off on request
	initial begin
		rsp_bus.ready <= 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_bus.ready <= 1'b0;
			end else begin
				rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready)
			sb.check_response(rsp_bus.payload);
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb = new();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_request = 1'b0;
		arst_n <= 1'b0;
		req_bus.valid <= 1'b0;
		req_bus.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle line on mark, then two frames queued while idle
		offer_item(REQ_TICK, 8'h00);
		offer_item(REQ_TICK, 8'hFF);
		offer_item(REQ_BYTE, 8'h00);
		offer_item(REQ_BYTE, 8'hFF);
		repeat (8) offer_item(REQ_TICK, 8'h00);
		wait_drained();

		// mostly ticks, sparse bytes in the later phases, under each idling mix
		for (int unsigned phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 63;
					hold_request = 1'b1;
				end
				default: begin
					send_idle_pct = 27;
					stall_pct = 27;
				end
			endcase
			run_phase(200, (phase < 2) ? 0 : (phase == 2 ? 2 : 4));
			wait_drained();
		end

		// overfill the frame queue so late bytes get refused
		send_idle_pct = 0;
		stall_pct = 0;
		for (int unsigned n = 0; n < 40; n++) begin
			if ($urandom_range(9) == 0)
				offer_item(REQ_TICK, 8'($urandom_range(255)));
			else
				offer_item(REQ_BYTE, 8'($urandom_range(255)));
		end
		wait_drained();
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
